// File: hdl/tedt_pkg.sv
// Shared types and codes for the unique edge table.
package tedt_pkg;

  // Request codes carried on req_type
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LINE  = 2'd1,
    REQ_TRI   = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Triangle edge selects: (a,b), (b,c), (c,a)
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

endpackage

// File: hdl/tedt_edge_ram.sv
// Edge storage: one write port, one read port with registered read data.
module tedt_edge_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the new entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read with registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/triangle_edge_dedup_table.sv
// Top level of the unique mesh edge table.
// Builds a table of unique vertex-pair edges held in one synchronous RAM of
// MAX_EDGES entries. Each item gives exactly one result. A clear or line item
// goes straight to the result state, a read item through the read state. A
// triangle item walks the stored entries once per edge, one entry per cycle
// through the RAM read port, until a match or the end of the stored entries;
// with merge_enable at 0 it skips the walk. One item is in work at a time; a
// finished result waits in the output register while the next item is taken
// in. The RAM needs no clearing after reset: only entries below the count are
// ever compared or returned.
module triangle_edge_dedup_table
  import tedt_pkg::*;
#(
  parameter int MAX_EDGES   = 1024,
  parameter int VERTEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] vertex_a,
  input  logic [15:0] vertex_b,
  input  logic [15:0] vertex_c,
  input  logic [9:0]  entry_index,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] edge_total,
  output logic [2:0]  added_mask,
  output logic        table_full,
  output logic [15:0] read_first,
  output logic [15:0] read_second,
  output logic        read_valid
);

  localparam int VB = VERTEX_BITS;
  localparam int AW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int IW = (CW > 10) ? CW : 10;

  state_t          state;
  logic            merge_enable;
  logic [CW-1:0]   count;
  logic [CW-1:0]   rd_ptr;
  logic            cmp_pend;
  logic [1:0]      edge_sel;
  logic [VB-1:0]   va, vb, vc;
  logic [9:0]      idx;
  logic [2:0]      mask;
  logic            full;
  logic            rd_valid;
  logic [VB-1:0]   rd_first, rd_second;

  logic [VB-1:0]   in_va, in_vb;
  logic [VB-1:0]   p, q;
  logic [VB-1:0]   mem_first, mem_second;
  logic            in_fire, room, hit, scan_end, idx_ok;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*VB-1:0] ram_wdata, ram_rdata;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_va    = VB'(vertex_a);
  assign in_vb    = VB'(vertex_b);
  assign room     = (count < CW'(MAX_EDGES));
  assign idx_ok   = (IW'(idx) < IW'(count));

  // Select the endpoints of the edge under search
  always_comb begin
    case (edge_sel)
      EDGE_AB: begin
        p = va;
        q = vb;
      end
      EDGE_BC: begin
        p = vb;
        q = vc;
      end
      default: begin
        p = vc;
        q = va;
      end
    endcase
  end

  // Compare the entry read last cycle in either orientation
  assign mem_first  = ram_rdata[2*VB-1:VB];
  assign mem_second = ram_rdata[VB-1:0];
  assign hit = cmp_pend && (((mem_first == p) && (mem_second == q)) ||
                            ((mem_first == q) && (mem_second == p)));
  assign scan_end = !cmp_pend && (rd_ptr == count);

  // RAM port control
  assign ram_we = (in_fire && (req_t'(req_type) == REQ_LINE) && room) ||
                  ((state == ST_SCAN) && !hit && scan_end && room);
  assign ram_waddr = count[AW-1:0];
  assign ram_wdata = (state == ST_IDLE) ? {in_va, in_vb} : {p, q};
  assign ram_re    = (in_fire && (req_t'(req_type) == REQ_READ)) ||
                     ((state == ST_SCAN) && (rd_ptr != count));
  assign ram_raddr = (state == ST_IDLE) ? AW'(entry_index) : rd_ptr[AW-1:0];

  tedt_edge_ram #(
    .DEPTH (MAX_EDGES),
    .WIDTH (2 * VB),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Sequencer, table count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      merge_enable <= 1'b1;
      count        <= '0;
      cmp_pend     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        merge_enable <= cfg_wr_data;
      end
      // drop the result once it is transferred, unless a new one replaces it
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            va       <= in_va;
            vb       <= in_vb;
            vc       <= VB'(vertex_c);
            idx      <= entry_index;
            mask     <= 3'b000;
            full     <= 1'b0;
            rd_valid <= 1'b0;
            edge_sel <= EDGE_AB;
            rd_ptr   <= '0;
            cmp_pend <= 1'b0;
            case (req_t'(req_type))
              REQ_CLEAR: begin
                count <= '0;
                state <= ST_DONE;
              end
              REQ_LINE: begin
                if (room) begin
                  count <= count + 1'b1;
                  mask  <= 3'b001;
                end else begin
                  full <= 1'b1;
                end
                state <= ST_DONE;
              end
              REQ_TRI: begin
                state <= merge_enable ? ST_SCAN : ST_DONE;
              end
              REQ_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          // capture the entry read at the requested index
          rd_valid  <= idx_ok;
          rd_first  <= mem_first;
          rd_second <= mem_second;
          state     <= ST_DONE;
        end
        ST_SCAN: begin
          if (hit || scan_end) begin
            // append an edge that was not found, or flag full, then advance to the next edge
            if (!hit) begin
              if (room) begin
                count          <= count + 1'b1;
                mask[edge_sel] <= 1'b1;
              end else begin
                full <= 1'b1;
              end
            end
            rd_ptr   <= '0;
            cmp_pend <= 1'b0;
            if (edge_sel == EDGE_CA) begin
              state <= ST_DONE;
            end else begin
              edge_sel <= edge_sel + 1'b1;
            end
          end else if (rd_ptr != count) begin
            rd_ptr   <= rd_ptr + 1'b1;
            cmp_pend <= 1'b1;
          end else begin
            cmp_pend <= 1'b0;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            edge_total  <= 11'(count);
            added_mask  <= mask;
            table_full  <= full;
            read_first  <= rd_valid ? 16'(rd_first) : 16'd0;
            read_second <= rd_valid ? 16'(rd_second) : 16'd0;
            read_valid  <= rd_valid;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_EDGES))
    else $error("edge count above table size");

  // Every RAM write appends exactly one entry
  a_write_appends: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (count == $past(count) + 1'b1))
    else $error("RAM write without count advance");

  // The scan pointer never runs past the stored entries
  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_ptr <= count))
    else $error("scan pointer past edge count");

  // A pending compare only exists while scanning
  a_cmp_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_pend |-> (state == ST_SCAN))
    else $error("compare pending outside scan");

endmodule

// File: test/edge_table_checker.sv
// Checker for the unique edge table: predicts each result and compares it on transfer.
module edge_table_checker
  import tedt_pkg::*;
#(
  parameter int MAX_EDGES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] vertex_a,
  input  logic [15:0] vertex_b,
  input  logic [15:0] vertex_c,
  input  logic [9:0]  entry_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] edge_total,
  input  logic [2:0]  added_mask,
  input  logic        table_full,
  input  logic [15:0] read_first,
  input  logic [15:0] read_second,
  input  logic        read_valid,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [10:0] total;
    logic [2:0]  mask;
    logic        full;
    logic [15:0] first;
    logic [15:0] second;
    logic        rvalid;
  } edge_result_t;

  // Shadow copy of the table and the enable register
  logic [15:0]  pair_first  [MAX_EDGES];
  logic [15:0]  pair_second [MAX_EDGES];
  int           stored_edges;
  logic         merge_on;
  edge_result_t expected_results[$];
  int           mismatches;

  // Search the stored pairs in both orientations
  function automatic bit edge_stored(input logic [15:0] p, input logic [15:0] q);
    for (int k = 0; k < stored_edges; k++) begin
      if ((pair_first[k] == p && pair_second[k] == q) ||
          (pair_first[k] == q && pair_second[k] == p))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // Append a pair; report failure when no room is left
  function automatic bit append_pair(input logic [15:0] p, input logic [15:0] q);
    if (stored_edges >= MAX_EDGES)
      return 1'b0;
    pair_first[stored_edges]  = p;
    pair_second[stored_edges] = q;
    stored_edges++;
    return 1'b1;
  endfunction

  function automatic void merge_edge(input logic [15:0] p, input logic [15:0] q,
                                     input logic [1:0] sel, inout edge_result_t r);
    if (!edge_stored(p, q)) begin
      if (append_pair(p, q))
        r.mask[sel] = 1'b1;
      else
        r.full = 1'b1;
    end
  endfunction

  // Advance the shadow table by one request and return its result
  function automatic edge_result_t apply_request(input req_t kind,
                                                 input logic [15:0] a,
                                                 input logic [15:0] b,
                                                 input logic [15:0] c,
                                                 input logic [9:0] idx);
    edge_result_t r;
    r = '0;
    case (kind)
      REQ_CLEAR: begin
        stored_edges = 0;
      end
      REQ_LINE: begin
        if (append_pair(a, b))
          r.mask = 3'b001;
        else
          r.full = 1'b1;
      end
      REQ_TRI: begin
        if (merge_on) begin
          merge_edge(a, b, EDGE_AB, r);
          merge_edge(b, c, EDGE_BC, r);
          merge_edge(c, a, EDGE_CA, r);
        end
      end
      REQ_READ: begin
        if (int'(idx) < stored_edges) begin
          r.rvalid = 1'b1;
          r.first  = pair_first[idx];
          r.second = pair_second[idx];
        end
      end
      default: ;
    endcase
    r.total = 11'(stored_edges);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Watch both channels and the register port at each edge
  always @(posedge clk) begin : monitor
    edge_result_t want;
    if (rst) begin
      stored_edges = 0;
      merge_on     = 1'b1;
      expected_results.delete();
    end else begin
      if (cfg_wr_en)
        merge_on = cfg_wr_data;
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(req_t'(req_type), vertex_a, vertex_b,
                                                 vertex_c, entry_index));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("edge_total", int'(want.total), int'(edge_total));
          check_field("added_mask", int'(want.mask), int'(added_mask));
          check_field("table_full", int'(want.full), int'(table_full));
          check_field("read_first", int'(want.first), int'(read_first));
          check_field("read_second", int'(want.second), int'(read_second));
          check_field("read_valid", int'(want.rvalid), int'(read_valid));
        end
      end
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

// File: test/testbench.sv
// Top of the unique edge table testbench: clock, reset, stimulus and verdict.
module testbench;
  import tedt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_EDGES   = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SMALL_POOL  = 11;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_CLEAR;
  logic [15:0] vertex_a = '0;
  logic [15:0] vertex_b = '0;
  logic [15:0] vertex_c = '0;
  logic [9:0]  entry_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] edge_total;
  logic [2:0]  added_mask;
  logic        table_full;
  logic [15:0] read_first;
  logic [15:0] read_second;
  logic        read_valid;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Last triangle sent, for building neighbors that share an edge
  logic [15:0] last_a = 16'd0;
  logic [15:0] last_b = 16'd1;
  logic [15:0] last_c = 16'd2;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_edge_dedup_table #(
    .MAX_EDGES  (MAX_EDGES),
    .VERTEX_BITS(16)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .vertex_a   (vertex_a),
    .vertex_b   (vertex_b),
    .vertex_c   (vertex_c),
    .entry_index(entry_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_total (edge_total),
    .added_mask (added_mask),
    .table_full (table_full),
    .read_first (read_first),
    .read_second(read_second),
    .read_valid (read_valid)
  );

  edge_table_checker #(
    .MAX_EDGES(MAX_EDGES)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .vertex_a   (vertex_a),
    .vertex_b   (vertex_b),
    .vertex_c   (vertex_c),
    .entry_index(entry_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_total (edge_total),
    .added_mask (added_mask),
    .table_full (table_full),
    .read_first (read_first),
    .read_second(read_second),
    .read_valid (read_valid),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one request, with random gaps ahead of it, and hold it until transfer
  task automatic send_request(input req_t kind, input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c, input logic [9:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    vertex_a    <= a;
    vertex_b    <= b;
    vertex_c    <= c;
    entry_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_merge_enable(input logic value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [15:0] pick_vertex();
    if ($urandom_range(99) < 65)
      return 16'($urandom_range(SMALL_POOL));
    return 16'($urandom);
  endfunction

  // Mostly mesh-like triangles over a small vertex pool, with lines, reads and clears
  task automatic send_random_request();
    int          roll;
    logic [15:0] a, b, c;
    logic [9:0]  idx;
    roll = $urandom_range(99);
    a = pick_vertex();
    b = pick_vertex();
    c = pick_vertex();
    idx = ($urandom_range(99) < 70) ? 10'($urandom_range(47)) : 10'($urandom);
    if (roll < 4) begin
      send_request(REQ_CLEAR, a, b, c, idx);
    end else if (roll < 22) begin
      send_request(REQ_LINE, a, b, c, idx);
    end else if (roll < 75) begin
      if ($urandom_range(99) < 40) begin
        // neighbor across the last triangle's edge, reversed orientation
        a = last_b;
        b = last_a;
      end
      last_a = a;
      last_b = b;
      last_c = c;
      send_request(REQ_TRI, a, b, c, idx);
    end else begin
      send_request(REQ_READ, a, b, c, idx);
    end
  endtask

  task automatic run_phase(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    repeat (count) send_random_request();
  endtask

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty reads, extreme vertices, duplicates and degenerate triangles
    send_request(REQ_READ,  16'h0000, 16'h0000, 16'h0000, 10'd0);
    send_request(REQ_READ,  16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
    send_request(REQ_LINE,  16'h0000, 16'h0000, 16'hFFFF, 10'd1023);
    send_request(REQ_LINE,  16'hFFFF, 16'hFFFF, 16'h0000, 10'd0);
    send_request(REQ_TRI,   16'd1, 16'd2, 16'd3, 10'd0);
    send_request(REQ_TRI,   16'd3, 16'd2, 16'd1, 10'd0);
    send_request(REQ_TRI,   16'd5, 16'd5, 16'd5, 10'd0);
    send_request(REQ_TRI,   16'd7, 16'd7, 16'd8, 10'd0);
    send_request(REQ_TRI,   16'hFFFF, 16'h0000, 16'hFFFF, 10'd0);
    send_request(REQ_READ,  16'd0, 16'd0, 16'd0, 10'd0);
    send_request(REQ_READ,  16'd0, 16'd0, 16'd0, 10'd1);
    send_request(REQ_READ,  16'd0, 16'd0, 16'd0, 10'd8);
    send_request(REQ_READ,  16'd0, 16'd0, 16'd0, 10'd9);
    send_request(REQ_LINE,  16'd1, 16'd2, 16'd9, 10'd0);
    send_request(REQ_TRI,   16'hAAAA, 16'h5555, 16'hFFFF, 10'h2AA);
    send_request(REQ_READ,  16'h5555, 16'hAAAA, 16'h5555, 10'd11);
    send_request(REQ_CLEAR, 16'd1, 16'd2, 16'd3, 10'h155);
    send_request(REQ_READ,  16'd0, 16'd0, 16'd0, 10'd0);

    // Triangles disabled: table stays, lines still append
    write_merge_enable(1'b0);
    send_request(REQ_TRI,   16'd1, 16'd2, 16'd3, 10'd0);
    send_request(REQ_LINE,  16'd4, 16'd5, 16'd6, 10'd0);
    send_request(REQ_TRI,   16'd4, 16'd6, 16'd5, 10'd0);
    send_request(REQ_READ,  16'd0, 16'd0, 16'd0, 10'd0);
    write_merge_enable(1'b1);

    // Keep offering lines while the result side holds off, then run triangles into them
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 10'd0);
    hold_ticket <= hold_ticket + 1;
    send_request(REQ_LINE, 16'd7, 16'd9, 16'd0, 10'd0);
    send_request(REQ_LINE, 16'd9, 16'd11, 16'd0, 10'd0);
    send_request(REQ_LINE, 16'd11, 16'd7, 16'd0, 10'd0);
    repeat (6)
      send_request(REQ_LINE, 16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
    send_request(REQ_TRI,  16'd11, 16'd9, 16'd7, 10'd0);
    send_request(REQ_TRI,  16'd7, 16'd9, 16'd7, 10'd0);
    send_request(REQ_TRI,  16'd40000, 16'd40001, 16'd40002, 10'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 10'd1023);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 10'd2);
    drain();

    // Random: sender busy, receiver sparse at first; triangles off for the second part
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 10'd0);
    run_phase(48, 11, 64);
    write_merge_enable(1'b0);
    run_phase(16, 64, 11);
    write_merge_enable(1'b1);
    run_phase(32, 64, 11);
    drain();
    run_phase(48, 0, 0);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
